@@ sv/loser_tree_kway_merge_top_macros.svh @@
// ---------------------------------------------------------------------------
// Loser-tree merge assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef LOSER_TREE_KWAY_MERGE_TOP_MACROS_SVH
`define LOSER_TREE_KWAY_MERGE_TOP_MACROS_SVH

`ifndef SYNTH
// clocked check, masked while reset is held
`define LTKM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// clocked check that also holds during reset
`define LTKM_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LTKM_ASSERT(lbl, clk, rstn, prop, msg)
`define LTKM_ASSERT_RST(lbl, clk, prop, msg)
`endif

`endif

@@ sv/ltkm_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ltkm_pkg
// Shared types and constants of the loser-tree merge selector.
// ---------------------------------------------------------------------------
package ltkm_pkg;

  localparam int DEF_WAYS = 8;

  localparam int FUNC_W = 2;
  localparam int RUN_W  = 3;
  localparam int KEY_W  = 16;

  // stream packing
  localparam int RUN_LSB     = 0;
  localparam int KEY_LSB     = RUN_LSB + RUN_W;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W   = OUT_TDATA_W - RUN_W - KEY_W;

  localparam logic signed [KEY_W-1:0] END_KEY   = 16'sh7FFF;
  localparam logic signed [KEY_W-1:0] LEAST_KEY = 16'sh8000;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_BUILD = 2'd1,
    FUNC_NEXT  = 2'd2
  } func_e;

  typedef struct packed {
    func_e                    func;
    logic [RUN_W-1:0]         run;
    logic signed [KEY_W-1:0]  key;
  } req_t;

  typedef struct packed {
    logic                     valid;
    logic [RUN_W-1:0]         run;
    logic signed [KEY_W-1:0]  key;
    logic                     done;
  } res_t;

endpackage

@@ sv/ltkm_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ltkm_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module ltkm_ram import ltkm_pkg::*; #(
  parameter  int WIDTH = KEY_W,
  parameter  int DEPTH = DEF_WAYS + 1,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/ltkm_seq.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ltkm_seq
// Tree sequencer: loads, build sweep and leaf-to-root replays.
// ---------------------------------------------------------------------------
`include "loser_tree_kway_merge_top_macros.svh"

module ltkm_seq import ltkm_pkg::*; #(
  parameter  int WAYS = DEF_WAYS,
  localparam int LW   = $clog2(WAYS + 1),
  localparam int NW   = $clog2(WAYS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  req_t             req_i,
  input  logic             out_ready_i,
  output res_t             res_o,
  // leaf key memory
  output logic             leaf_we_o,
  output logic [LW-1:0]    leaf_waddr_o,
  output logic [KEY_W-1:0] leaf_wdata_o,
  output logic             leaf_re_o,
  output logic [LW-1:0]    leaf_raddr_o,
  input  logic [KEY_W-1:0] leaf_rdata_i,
  // loser node memory
  output logic             node_we_o,
  output logic [NW-1:0]    node_waddr_o,
  output logic [LW-1:0]    node_wdata_o,
  output logic             node_re_o,
  output logic [NW-1:0]    node_raddr_o,
  input  logic [LW-1:0]    node_rdata_i
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SWEEP  = 7'b0000010,
    ST_START  = 7'b0000100,
    ST_RDLEAF = 7'b0001000,
    ST_CMP    = 7'b0010000,
    ST_RDWIN  = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_e;

  localparam logic [LW-1:0] SENT      = LW'(WAYS);
  localparam logic [LW-1:0] LAST_LEAF = LW'(WAYS - 1);

  // parent node of a leaf: (leaf + WAYS) / 2
  function automatic logic [NW-1:0] first_node(input logic [LW-1:0] leaf);
    logic [LW:0] sum;
    sum = {1'b0, leaf} + (LW+1)'(WAYS);
    return sum[NW:1];
  endfunction

  state_e                  state_q, state_d;
  logic [LW-1:0]           climb_q, climb_d;
  logic signed [KEY_W-1:0] climb_key_q, climb_key_d;
  logic [LW-1:0]           held_q, held_d;
  logic [NW-1:0]           node_q, node_d;
  logic [LW-1:0]           root_q, root_d;
  logic [LW-1:0]           cnt_q, cnt_d;
  logic                    build_q, build_d;
  logic                    first_q, first_d;

  logic                    accept;
  logic [RUN_W+LW-1:0]     run_ext;
  logic                    run_ok;
  logic [LW-1:0]           held_c;
  logic signed [KEY_W-1:0] held_key;
  logic                    swap;
  logic [LW-1:0]           climb_nx;
  logic [NW-1:0]           node_up;
  logic [RUN_W+LW-1:0]     climb_ext;

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;

  assign run_ext = {{LW{1'b0}}, req_i.run};
  assign run_ok  = (run_ext < (RUN_W+LW)'(WAYS));

  // stale node contents beyond the sentinel read as the sentinel
  assign held_c   = (node_rdata_i > SENT) ? SENT : node_rdata_i;
  assign held_key = leaf_rdata_i;
  // challenger stays on equal keys
  assign swap     = (climb_key_q > held_key);
  assign climb_nx = swap ? held_q : climb_q;
  assign node_up  = node_q >> 1;

  assign climb_ext = {{RUN_W{1'b0}}, climb_q};

  always_comb begin
    state_d      = state_q;
    climb_d      = climb_q;
    climb_key_d  = climb_key_q;
    held_d       = held_q;
    node_d       = node_q;
    root_d       = root_q;
    cnt_d        = cnt_q;
    build_d      = build_q;
    first_d      = first_q;
    leaf_we_o    = 1'b0;
    leaf_waddr_o = run_ext[LW-1:0];
    leaf_wdata_o = req_i.key;
    leaf_re_o    = 1'b0;
    leaf_raddr_o = cnt_q;
    node_we_o    = 1'b0;
    node_waddr_o = node_q;
    node_wdata_o = climb_q;
    node_re_o    = 1'b0;
    node_raddr_o = first_node(cnt_q);
    res_o.valid  = 1'b0;
    res_o.run    = climb_ext[RUN_W-1:0];
    res_o.key    = climb_key_q;
    res_o.done   = (climb_key_q == END_KEY);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_i.func)
            FUNC_LOAD: begin
              leaf_we_o = run_ok;
            end
            FUNC_BUILD: begin
              leaf_we_o    = 1'b1;
              leaf_waddr_o = SENT;
              leaf_wdata_o = LEAST_KEY;
              cnt_d        = '0;
              build_d      = 1'b1;
              root_d       = SENT;
              state_d      = ST_SWEEP;
            end
            FUNC_NEXT: begin
              build_d = 1'b0;
              climb_d = root_q;
              if (root_q == SENT) begin
                leaf_re_o    = 1'b1;
                leaf_raddr_o = root_q;
                state_d      = ST_RDWIN;
              end else begin
                leaf_we_o    = 1'b1;
                leaf_waddr_o = root_q;
                climb_key_d  = req_i.key;
                node_re_o    = 1'b1;
                node_raddr_o = first_node(root_q);
                node_d       = first_node(root_q);
                first_d      = 1'b0;
                state_d      = ST_RDLEAF;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SWEEP: begin
        node_we_o    = 1'b1;
        node_waddr_o = cnt_q[NW-1:0];
        node_wdata_o = SENT;
        if (cnt_q == LAST_LEAF) begin
          state_d = ST_START;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_START: begin
        leaf_re_o    = 1'b1;
        leaf_raddr_o = cnt_q;
        node_re_o    = 1'b1;
        node_raddr_o = first_node(cnt_q);
        climb_d      = cnt_q;
        node_d       = first_node(cnt_q);
        first_d      = 1'b1;
        state_d      = ST_RDLEAF;
      end
      ST_RDLEAF: begin
        held_d       = held_c;
        leaf_re_o    = 1'b1;
        leaf_raddr_o = held_c;
        if (first_q) begin
          climb_key_d = leaf_rdata_i;
          first_d     = 1'b0;
        end
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (swap) begin
          node_we_o   = 1'b1;
          climb_d     = held_q;
          climb_key_d = held_key;
        end
        if (node_up == '0) begin
          root_d = climb_nx;
          if (build_q && (cnt_q != '0)) begin
            cnt_d   = cnt_q - 1'b1;
            state_d = ST_START;
          end else begin
            state_d = ST_EMIT;
          end
        end else begin
          node_d       = node_up;
          node_re_o    = 1'b1;
          node_raddr_o = node_up;
          state_d      = ST_RDLEAF;
        end
      end
      ST_RDWIN: begin
        climb_key_d = leaf_rdata_i;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          res_o.valid = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      root_q  <= '0;
      cnt_q   <= '0;
      build_q <= 1'b0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      root_q  <= root_d;
      cnt_q   <= cnt_d;
      build_q <= build_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    climb_q     <= climb_d;
    climb_key_q <= climb_key_d;
    held_q      <= held_d;
    node_q      <= node_d;
  end

  `LTKM_ASSERT(a_node_rw_apart, clk_i, rst_ni, (node_we_o && node_re_o) |-> (node_waddr_o != node_raddr_o), "loser node read and written at one address")
  `LTKM_ASSERT(a_leaf_port_excl, clk_i, rst_ni, !(leaf_we_o && leaf_re_o), "leaf memory read and written in one cycle")
  `LTKM_ASSERT(a_root_range, clk_i, rst_ni, (root_q <= SENT) && (held_q <= SENT || state_q != ST_CMP), "leaf index beyond sentinel")
  `LTKM_ASSERT_RST(a_reset_idle, clk_i, !rst_ni |=> ((state_q == ST_IDLE) && !res_o.valid), "sequencer not idle in reset")

endmodule

@@ sv/loser_tree_kway_merge_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// loser_tree_kway_merge_top
// Loser-tree selector for a K-way merge of sorted runs.
// ---------------------------------------------------------------------------
//
//  channel  | dir | tdata (low bit first)          | tuser
//  ---------+-----+--------------------------------+-------------
//  s_axis   | in  | run_index[2:0], key[15:0], pad | func[1:0]
//  m_axis   | out | winner_run[2:0], winner_key    | all_done
//
//  Load writes one leaf key. Next replays the winner leaf's path over L
//  levels (3 at eight ways); each level is a loser node read followed by
//  a leaf key read, both from RAMs with a registered read port. Build
//  sweeps every node to the sentinel, then replays each leaf, last first.
//  Reset clears control state only; both RAMs hold garbage until loaded
//  or built. A result waits in the output register under back-pressure
//  while the next item is already taken.
//
module loser_tree_kway_merge_top import ltkm_pkg::*; #(
  parameter  int WAYS = DEF_WAYS,
  localparam int LW   = $clog2(WAYS + 1),
  localparam int NW   = $clog2(WAYS)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // item in
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // run_index[2:0], key[18:3], zero pad
  input  logic [FUNC_W-1:0]      s_axis_tuser,   // func[1:0]
  // result out
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // winner_run[2:0], winner_key[18:3], zero pad
  output logic                   m_axis_tuser    // all_done
);

  req_t             req;
  res_t             res;
  logic             slot_free;

  logic             leaf_we, leaf_re;
  logic [LW-1:0]    leaf_waddr, leaf_raddr;
  logic [KEY_W-1:0] leaf_wdata, leaf_rdata;

  logic             node_we, node_re;
  logic [NW-1:0]    node_waddr, node_raddr;
  logic [LW-1:0]    node_wdata, node_rdata;

  // output stage
  logic                    out_valid_q;
  logic [RUN_W-1:0]        out_run_q;
  logic signed [KEY_W-1:0] out_key_q;
  logic                    out_done_q;

  assign req.func = func_e'(s_axis_tuser);
  assign req.run  = s_axis_tdata[RUN_LSB +: RUN_W];
  assign req.key  = s_axis_tdata[KEY_LSB +: KEY_W];

  // slot can take a result now if empty or being drained this cycle
  assign slot_free = !out_valid_q || m_axis_tready;

  ltkm_seq #(
    .WAYS (WAYS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_o  (s_axis_tready),
    .req_i        (req),
    .out_ready_i  (slot_free),
    .res_o        (res),
    .leaf_we_o    (leaf_we),
    .leaf_waddr_o (leaf_waddr),
    .leaf_wdata_o (leaf_wdata),
    .leaf_re_o    (leaf_re),
    .leaf_raddr_o (leaf_raddr),
    .leaf_rdata_i (leaf_rdata),
    .node_we_o    (node_we),
    .node_waddr_o (node_waddr),
    .node_wdata_o (node_wdata),
    .node_re_o    (node_re),
    .node_raddr_o (node_raddr),
    .node_rdata_i (node_rdata)
  );

  // leaf keys, slot WAYS is the sentinel
  ltkm_ram #(
    .WIDTH (KEY_W),
    .DEPTH (WAYS + 1)
  ) u_leaf_ram (
    .clk_i   (clk_i),
    .we_i    (leaf_we),
    .waddr_i (leaf_waddr),
    .wdata_i (leaf_wdata),
    .re_i    (leaf_re),
    .raddr_i (leaf_raddr),
    .rdata_o (leaf_rdata)
  );

  // loser leaf index per inner node
  ltkm_ram #(
    .WIDTH (LW),
    .DEPTH (WAYS)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .re_i    (node_re),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_run_q  <= res.run;
      out_key_q  <= res.key;
      out_done_q <= res.done;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_key_q, out_run_q};
  assign m_axis_tuser  = out_done_q;

endmodule

@@ test/loser_tree_kway_merge_top_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// loser_tree_kway_merge_top_tb
// Self-checking bench for the loser-tree merge selector: loads, builds and
// winner replacements go in over the item stream, and a bench-side copy of
// the tree predicts every winner report that comes back.
// ---------------------------------------------------------------------------
module loser_tree_kway_merge_top_tb;
  import ltkm_pkg::*;

  localparam int WAYS        = DEF_WAYS;
  localparam int ITEM_TARGET = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_TAIL  = 100;   // longer than one build

  typedef struct {
    logic [RUN_W-1:0]        run;
    logic signed [KEY_W-1:0] key;
    logic                    done;
  } winner_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [FUNC_W-1:0]      s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  loser_tree_kway_merge_top #(.WAYS(WAYS)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // bench copy of the tree
  logic signed [KEY_W-1:0] leaf_key [0:WAYS];
  int                      loser_of [0:WAYS-1];
  int                      root_leaf;
  winner_t                 pending_winners[$];

  int  errors;
  int  items_sent;
  int  burst_left;
  bit  hold_req;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // climb from one leaf to the root, leaving the loser of each match behind
  function automatic void replay_path(int leaf);
    int climb;
    int node;
    int held;
    climb = leaf;
    node  = (climb + WAYS) / 2;
    while (node > 0) begin
      held = loser_of[node];
      if (leaf_key[climb] > leaf_key[held]) begin
        loser_of[node] = climb;
        climb = held;
      end
      node = node / 2;
    end
    root_leaf = climb;
  endfunction

  function automatic void predict_winner(logic [FUNC_W-1:0] fn, logic [RUN_W-1:0] run,
                                         logic signed [KEY_W-1:0] k);
    winner_t w;
    if (fn == FUNC_LOAD) begin
      if (int'(run) < WAYS) leaf_key[run] = k;
      return;
    end
    if (fn == FUNC_BUILD) begin
      leaf_key[WAYS] = LEAST_KEY;
      for (int i = 0; i < WAYS; i++) loser_of[i] = WAYS;
      root_leaf = WAYS;
      for (int i = WAYS - 1; i >= 0; i--) replay_path(i);
    end else if (fn == FUNC_NEXT) begin
      // a sentinel winner leaves the tree untouched
      if (root_leaf < WAYS) begin
        leaf_key[root_leaf] = k;
        replay_path(root_leaf);
      end
    end else begin
      return;
    end
    w.run  = RUN_W'(root_leaf);
    w.key  = leaf_key[root_leaf];
    w.done = (leaf_key[root_leaf] == END_KEY);
    pending_winners.push_back(w);
  endfunction

  // one transfer on the item side, with bursty gaps in front
  task automatic send_item(logic [FUNC_W-1:0] fn, logic [RUN_W-1:0] run,
                           logic signed [KEY_W-1:0] k);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - KEY_LSB - KEY_W){1'b0}}, k, run};
    s_axis_tuser  <= fn;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_winner(fn, run, k);
    items_sent++;
  endtask

  // stop offering the last item before waiting, so it is not taken twice
  task automatic wait_results;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_winners.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_noise(int count);
    repeat (count)
      send_item(FUNC_W'($urandom_range(0, 3)), RUN_W'($urandom), KEY_W'($urandom));
  endtask

  // sorted runs of random length; each replacement key follows the winner's
  // current key, and an empty run hands in the end key
  task automatic run_merge;
    int                      remaining [WAYS];
    int                      steps;
    int                      nk;
    logic signed [KEY_W-1:0] first;
    for (int i = 0; i < WAYS; i++) begin
      remaining[i] = $urandom_range(0, 5);
      first = ($urandom_range(0, 9) == 0) ? END_KEY : KEY_W'($urandom);
      send_item(FUNC_LOAD, RUN_W'(i), first);
    end
    send_item(FUNC_BUILD, RUN_W'($urandom), KEY_W'($urandom));
    steps = 0;
    while (root_leaf < WAYS && leaf_key[root_leaf] != END_KEY && steps < 64) begin
      if (remaining[root_leaf] == 0) begin
        nk = END_KEY;
      end else begin
        remaining[root_leaf]--;
        nk = int'(leaf_key[root_leaf]) + int'($urandom_range(0, 3000));
        if (nk > 32766) nk = 32766;
      end
      send_item(FUNC_NEXT, RUN_W'($urandom), KEY_W'(nk));
      steps++;
    end
  endtask

  task automatic test_directed;
    // field extremes in the leaves, then replacements at both key limits
    send_item(FUNC_LOAD, 3'd0, END_KEY);
    send_item(FUNC_LOAD, 3'd1, -16'sd32767);
    send_item(FUNC_LOAD, 3'd2, 16'sd0);
    send_item(FUNC_LOAD, 3'd3, 16'sd1);
    send_item(FUNC_LOAD, 3'd4, -16'sd1);
    send_item(FUNC_LOAD, 3'd5, 16'sd12345);
    send_item(FUNC_LOAD, 3'd6, 16'sd32766);
    send_item(FUNC_LOAD, 3'd7, -16'sd100);
    send_item(FUNC_BUILD, 3'd0, 16'sd0);
    send_item(FUNC_NEXT, 3'd7, LEAST_KEY);
    send_item(FUNC_NEXT, 3'd0, END_KEY);
    send_item(FUNC_NEXT, 3'd0, END_KEY);
    // unknown function code: no transfer out
    send_item(2'd3, 3'd5, 16'sh5555);
    // every run exhausted: winner holds the end key
    for (int i = 0; i < WAYS; i++) send_item(FUNC_LOAD, RUN_W'(i), END_KEY);
    send_item(FUNC_BUILD, 3'd7, 16'shAAAA);
    send_item(FUNC_NEXT, 3'd2, END_KEY);
    // a leaf equal to the sentinel key lets the sentinel reach the root
    send_item(FUNC_LOAD, 3'd7, LEAST_KEY);
    send_item(FUNC_BUILD, 3'd0, 16'sd0);
    send_item(FUNC_NEXT, 3'd4, 16'sd77);
    wait_results();
  endtask

  task automatic test_backpressure;
    hold_req = 1'b1;
    run_merge();
    wait_results();
  endtask

  task automatic test_random_mix;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 4) == 0) send_noise($urandom_range(1, 8));
      else run_merge();
    end
    wait_results();
  endtask

  // receiver: random stall patterns, long hold on request
  initial begin
    int cyc;
    int mode;
    m_axis_tready = 1'b0;
    cyc  = 0;
    mode = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if (cyc % 50 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= $urandom_range(0, 1);
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= cyc[0];
      endcase
      cyc++;
    end
  end

  // result check against the oldest prediction
  always @(posedge clk_i) begin
    winner_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_winners.size() == 0) begin
        $error("unexpected result: winner_run %0d winner_key %0d all_done %0b",
               m_axis_tdata[RUN_LSB +: RUN_W], $signed(m_axis_tdata[KEY_LSB +: KEY_W]),
               m_axis_tuser);
        errors++;
      end else begin
        w = pending_winners.pop_front();
        if (m_axis_tdata[RUN_LSB +: RUN_W] !== w.run) begin
          $error("winner_run: expected %0d, got %0d", w.run, m_axis_tdata[RUN_LSB +: RUN_W]);
          errors++;
        end
        if (m_axis_tdata[KEY_LSB +: KEY_W] !== w.key) begin
          $error("winner_key: expected %0d, got %0d", w.key,
                 $signed(m_axis_tdata[KEY_LSB +: KEY_W]));
          errors++;
        end
        if (m_axis_tuser !== w.done) begin
          $error("all_done: expected %0b, got %0b", w.done, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $error("no transfer for %0d cycles", STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    errors        = 0;
    items_sent    = 0;
    burst_left    = 0;
    hold_req      = 1'b0;
    root_leaf     = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_mix();
    test_backpressure();

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait_results();
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (pending_winners.size() != 0) begin
      $error("%0d predicted results never arrived", pending_winners.size());
      errors++;
    end
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
